// File: design/ssw_pkg.sv
// ----------------------------------------------------------------------------
// Staircase step sweep package
// Shared widths, register codes, request and result types, and the helper
// functions that clamp the sweep limits.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int MAX_STEP = 20;
    localparam int STEP_W   = 5;
    localparam int DWELL_W  = 10;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = VAL_W + STEP_W;
    localparam int MAG_W    = PROD_W - 1;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [7:0] MAX_STEP_8 = 8'(MAX_STEP);

    localparam logic [1:0] REG_DWELL  = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;
    localparam logic [1:0] REG_SOURCE = 2'd3;

    typedef struct packed {
        logic action;
        logic enabled;
    } ssw_in_t;

    typedef struct packed {
        logic [STEP_W-1:0]       step_index;
        logic signed [VAL_W-1:0] output_value;
    } ssw_out_t;

    typedef struct packed {
        logic [DWELL_W-1:0]      dwell_ticks;
        logic [STEP_W-1:0]       low_step;
        logic [STEP_W-1:0]       high_step;
        logic signed [VAL_W-1:0] source_value;
    } ssw_cfg_t;

    function automatic logic [STEP_W-1:0] eff_high(input logic [STEP_W-1:0] h);
        logic [STEP_W-1:0] r;
        r = (h == '0) ? STEP_W'(1) : h;
        if ({{(8-STEP_W){1'b0}}, r} > MAX_STEP_8) begin
            r = MAX_STEP_8[STEP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] eff_low(input logic [STEP_W-1:0] l,
                                                  input logic [STEP_W-1:0] h);
        logic [STEP_W-1:0] eh;
        eh = eff_high(h);
        return (l > eh) ? eh : l;
    endfunction

endpackage

// File: design/ssw_apb_regs.sv
// ----------------------------------------------------------------------------
// Staircase step sweep register file
// APB-style slave holding the dwell, step limit and source value settings.
// ----------------------------------------------------------------------------
module ssw_apb_regs import ssw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ssw_cfg_t          cfg
);

    ssw_cfg_t   cfg_reg;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dwell_ticks  <= DWELL_W'(10);
            cfg_reg.low_step     <= STEP_W'(1);
            cfg_reg.high_step    <= STEP_W'(1);
            cfg_reg.source_value <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DWELL:  cfg_reg.dwell_ticks  <= pwdata[DWELL_W-1:0];
                REG_LOW:    cfg_reg.low_step     <= pwdata[STEP_W-1:0];
                REG_HIGH:   cfg_reg.high_step    <= pwdata[STEP_W-1:0];
                REG_SOURCE: cfg_reg.source_value <= pwdata[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DWELL:  prdata = {{(DATA_W-DWELL_W){1'b0}}, cfg_reg.dwell_ticks};
            REG_LOW:    prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.low_step};
            REG_HIGH:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.high_step};
            REG_SOURCE: prdata = {{(DATA_W-VAL_W){1'b0}}, cfg_reg.source_value};
            default:    prdata = '0;
        endcase
    end

endmodule

// File: design/ssw_divider.sv
// ----------------------------------------------------------------------------
// Staircase step sweep divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssw_divider import ssw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic              done,
    output logic [MAG_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(MAG_W);

    logic [STEP_W-1:0] rem_reg,  rem_next;
    logic [MAG_W-1:0]  quo_reg,  quo_next;
    logic [STEP_W-1:0] dvs_reg,  dvs_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W:0]   trial;
    logic              fits;

    assign trial    = {rem_reg, quo_reg[MAG_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? STEP_W'(trial - {1'b0, dvs_reg}) : trial[STEP_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
        end
    end

endmodule

// File: design/staircase_step_sweep_core.sv
// A restart or a moving tick runs through the multiply, start, divide and finish states.
// A tick that does not move the step gives no result.
// A new request is taken only in idle, once the shared divider has finished the last one.
// The finished result waits in an output register while the next request is taken.
// Reset (synchronous, active low) clears the sweep state and loads the default settings.
// ----------------------------------------------------------------------------
// Staircase step sweep core
// Sequencer for the dwell counter and step walk, with a multiply stage that scales the
// source value by the step and a shared iterative divider that divides it by the high step.
// ----------------------------------------------------------------------------
module staircase_step_sweep_core import ssw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssw_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssw_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                   state_reg,   state_next;
    logic [DWELL_W-1:0]       dwell_reg,   dwell_next;
    logic [STEP_W-1:0]        step_reg,    step_next;
    logic                     down_reg,    down_next;
    logic signed [PROD_W-1:0] prod_reg,    prod_next;
    logic                     neg_reg,     neg_next;
    logic                     m_valid_reg, m_valid_next;
    ssw_out_t                 m_data_reg,  m_data_next;

    ssw_cfg_t                 cfg;
    logic [STEP_W-1:0]        hi_step;
    logic [STEP_W-1:0]        lo_step;
    logic [STEP_W-1:0]        step_mv;
    logic                     down_mv;
    logic [DWELL_W-1:0]       dwell_inc;
    logic signed [PROD_W-1:0] mul_res;
    logic signed [PROD_W-1:0] prod_abs;
    logic                     div_start;
    logic                     div_done;
    logic [MAG_W-1:0]         div_quo;
    logic [MAG_W-1:0]         quo_neg;
    logic signed [VAL_W-1:0]  sat_val;
    logic                     m_load;

    ssw_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssw_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_abs[MAG_W-1:0]),
        .divisor  (hi_step),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign hi_step   = eff_high(cfg.high_step);
    assign lo_step   = eff_low(cfg.low_step, cfg.high_step);
    assign dwell_inc = dwell_reg + DWELL_W'(1);
    assign mul_res   = PROD_W'(cfg.source_value) * PROD_W'($signed({1'b0, step_reg}));
    assign prod_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign quo_neg   = MAG_W'(0) - div_quo;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        step_mv = step_reg;
        down_mv = down_reg;
        if (step_reg < hi_step && !down_reg) begin
            step_mv = step_reg + STEP_W'(1);
        end else begin
            down_mv = 1'b1;
        end
        if (step_mv > lo_step && down_mv) begin
            step_mv = step_mv - STEP_W'(1);
        end else begin
            down_mv = 1'b0;
        end
    end

    always_comb begin
        if (!neg_reg) begin
            sat_val = (div_quo > MAG_W'(32767)) ? 16'sh7FFF : div_quo[VAL_W-1:0];
        end else begin
            sat_val = (div_quo > MAG_W'(32768)) ? 16'sh8000 : quo_neg[VAL_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        dwell_next   = dwell_reg;
        step_next    = step_reg;
        down_next    = down_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        m_load       = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.action) begin
                        step_next  = lo_step;
                        dwell_next = '0;
                        down_next  = 1'b0;
                        state_next = ST_MUL;
                    end else if (s_data.enabled) begin
                        if (dwell_inc < cfg.dwell_ticks) begin
                            dwell_next = dwell_inc;
                        end else begin
                            dwell_next = '0;
                            step_next  = step_mv;
                            down_next  = down_mv;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                prod_next  = mul_res;
                state_next = ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                neg_next   = prod_reg[PROD_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_load                   = 1'b1;
                    m_valid_next             = 1'b1;
                    m_data_next.step_index   = step_reg;
                    m_data_next.output_value = sat_val;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dwell_reg   <= '0;
            step_reg    <= STEP_W'(1);
            down_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dwell_reg   <= dwell_next;
            step_reg    <= step_next;
            down_reg    <= down_next;
            m_valid_reg <= m_valid_next;
            prod_reg    <= prod_next;
            neg_reg     <= neg_next;
            m_data_reg  <= m_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("Divider finished outside the divide state.");

    a_restart_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action |=> state_reg == ST_MUL)
        else $error("Restart request did not start the scaling sequence.");

    a_load_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("Result load did not present a result and return to idle.");

    a_result_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("Result appeared without a finished computation.");
`endif

endmodule

// File: test/tb_staircase_step_sweep_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Staircase step sweep core testbench
// Drives tick and restart requests and programs the sweep registers over the
// APB port. An internal copy of the sweep state predicts each step index and
// scaled output value, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_staircase_step_sweep_core;
    import ssw_pkg::*;

    localparam logic ACT_TICK     = 1'b0;
    localparam logic ACT_RESTART  = 1'b1;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   LONG_HOLD     = 500;
    localparam int   LIMIT_CYCLES  = 600000;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ssw_in_t           s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ssw_out_t          m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ssw_cfg_t          sweep_cfg = '{dwell_ticks: 10, low_step: 1, high_step: 1,
                                     source_value: 0};
    logic [DWELL_W-1:0] dwell_cnt  = '0;
    logic [STEP_W-1:0]  cur_step   = STEP_W'(1);
    bit                 descending = 1'b0;

    ssw_out_t expected_levels[$];
    ssw_out_t want_level;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       idle_off       = 1'b0;
    bit       hold_pending   = 1'b0;
    int       ready_stall;

    staircase_step_sweep_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap(input int long_max);
        int r;
        if (idle_off) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, long_max);
    endfunction

    function automatic logic [STEP_W-1:0] top_step();
        if (sweep_cfg.high_step == '0) begin
            return STEP_W'(1);
        end
        if (sweep_cfg.high_step > MAX_STEP) begin
            return STEP_W'(MAX_STEP);
        end
        return sweep_cfg.high_step;
    endfunction

    function automatic logic [STEP_W-1:0] bottom_step();
        logic [STEP_W-1:0] hi;
        hi = top_step();
        return (sweep_cfg.low_step > hi) ? hi : sweep_cfg.low_step;
    endfunction

    // The product is formed at full width, divided with truncation toward zero,
    // and then clamped to the 16-bit range.
    function automatic ssw_out_t current_level();
        int       src;
        int       q;
        ssw_out_t lvl;
        src = $signed(sweep_cfg.source_value);
        q = (src * int'(cur_step)) / int'(top_step());
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        lvl.step_index   = cur_step;
        lvl.output_value = q[VAL_W-1:0];
        return lvl;
    endfunction

    function automatic void advance_sweep(input ssw_in_t req);
        logic [STEP_W-1:0] hi;
        logic [STEP_W-1:0] lo;
        if (req.action == ACT_RESTART) begin
            cur_step   = bottom_step();
            dwell_cnt  = '0;
            descending = 1'b0;
            expected_levels.push_back(current_level());
            return;
        end
        if (!req.enabled) begin
            return;
        end
        dwell_cnt = dwell_cnt + 1'b1;
        if (dwell_cnt < sweep_cfg.dwell_ticks) begin
            return;
        end
        dwell_cnt = '0;
        hi = top_step();
        lo = bottom_step();
        if (cur_step < hi && !descending) begin
            cur_step = cur_step + 1'b1;
        end else begin
            descending = 1'b1;
        end
        if (cur_step > lo && descending) begin
            cur_step = cur_step - 1'b1;
        end else begin
            descending = 1'b0;
        end
        expected_levels.push_back(current_level());
    endfunction

    function automatic ssw_in_t make_request(input logic action, input logic enabled);
        ssw_in_t req;
        req.action  = action;
        req.enabled = enabled;
        return req;
    endfunction

    function automatic ssw_in_t random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return make_request(ACT_RESTART, 1'($urandom_range(0, 1)));
        end
        if (r < 16) begin
            return make_request(ACT_TICK, 1'b0);
        end
        return make_request(ACT_TICK, 1'b1);
    endfunction

    task automatic offer_request(input ssw_in_t req);
        int gap;
        gap = pick_gap(40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_sweep(req);
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DWELL:  sweep_cfg.dwell_ticks  = value[DWELL_W-1:0];
            REG_LOW:    sweep_cfg.low_step     = value[STEP_W-1:0];
            REG_HIGH:   sweep_cfg.high_step    = value[STEP_W-1:0];
            REG_SOURCE: sweep_cfg.source_value = value[VAL_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_sweep(input int dwell, input int low, input int high,
                             input logic [VAL_W-1:0] src);
        write_register(REG_DWELL, DATA_W'(dwell));
        write_register(REG_LOW, DATA_W'(low));
        write_register(REG_HIGH, DATA_W'(high));
        write_register(REG_SOURCE, DATA_W'(src));
    endtask

    // Receiver side: random stalls, with a long hold when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                ready_stall  = LONG_HOLD;
            end else begin
                ready_stall = pick_gap(60);
            end
            if (ready_stall > 0) begin
                m_ready <= 1'b0;
                repeat (ready_stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual step %0d value %0d",
                         $time, m_data.step_index, m_data.output_value);
                mismatch_count++;
            end else begin
                want_level = expected_levels.pop_front();
                if (m_data.step_index !== want_level.step_index) begin
                    $display("%0t: step_index expected %0d actual %0d",
                             $time, want_level.step_index, m_data.step_index);
                    mismatch_count++;
                end
                if (m_data.output_value !== want_level.output_value) begin
                    $display("%0t: output_value expected %0d actual %0d",
                             $time, want_level.output_value, m_data.output_value);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_default_settings();
        offer_request(make_request(ACT_RESTART, 1'b1));
        offer_request(make_request(ACT_TICK, 1'b0));
        offer_request(make_request(ACT_RESTART, 1'b0));
        repeat (10) offer_request(make_request(ACT_TICK, 1'b1));
        wait_for_idle();
    endtask

    task automatic test_sweep_walk();
        set_sweep(0, 0, 2, 16'h8000);
        offer_request(make_request(ACT_RESTART, 1'b1));
        repeat (5) offer_request(make_request(ACT_TICK, 1'b1));
        wait_for_idle();
    endtask

    task automatic test_index_above_high();
        set_sweep(0, 20, 20, 16'h7FFF);
        offer_request(make_request(ACT_RESTART, 1'b1));
        wait_for_idle();
        set_sweep(0, 20, 1, 16'h8000);
        offer_request(make_request(ACT_TICK, 1'b1));
        wait_for_idle();
        write_register(REG_SOURCE, DATA_W'(16'h7FFF));
        offer_request(make_request(ACT_TICK, 1'b1));
        wait_for_idle();
    endtask

    task automatic test_random_sweeps();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_sweep(0, 0, 20, 16'h7FFF);
                1: set_sweep(1, 3, 7, 16'h8000);
                2: set_sweep(2, 5, 5, VAL_W'($urandom_range(0, 65535)));
                3: set_sweep(0, 31, 0, 16'hFFFF);
                4: set_sweep(3, 0, 31, VAL_W'($urandom_range(0, 65535)));
                5: set_sweep(0, 25, 9, VAL_W'($urandom_range(0, 65535)));
                default: set_sweep($urandom_range(0, 4), $urandom_range(0, 31),
                                   $urandom_range(0, 31), VAL_W'($urandom_range(0, 65535)));
            endcase
            idle_off = (phase == 2);
            repeat (70) offer_request(random_request());
            idle_off = 1'b0;
            wait_for_idle();
        end
    endtask

    task automatic test_long_dwell();
        ssw_in_t req;
        int      enabled_sent;
        set_sweep(40, 2, 6, VAL_W'($urandom_range(0, 65535)));
        idle_off = 1'b1;
        offer_request(make_request(ACT_RESTART, 1'b1));
        enabled_sent = 0;
        while (enabled_sent < 81) begin
            req = make_request(ACT_TICK, 1'($urandom_range(0, 99) < 95));
            offer_request(req);
            if (req.enabled) begin
                enabled_sent++;
            end
        end
        idle_off = 1'b0;
        wait_for_idle();
    endtask

    task automatic test_output_backpressure();
        set_sweep(0, 0, 20, VAL_W'($urandom_range(0, 65535)));
        hold_pending = 1'b1;
        idle_off     = 1'b1;
        repeat (24) begin
            if ($urandom_range(0, 99) < 20) begin
                offer_request(make_request(ACT_RESTART, 1'b1));
            end else begin
                offer_request(make_request(ACT_TICK, 1'b1));
            end
        end
        idle_off = 1'b0;
        wait_for_idle();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_settings();
        test_sweep_walk();
        test_index_above_high();
        test_random_sweeps();
        test_long_dwell();
        test_output_backpressure();
        wait_for_idle();
        if (mismatch_count == 0 && expected_levels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
